>>> hw/rtl/pcmx_pkg.sv
// Shared types, constants and the pan gain table for the PCM sample mixer.
// Used by every module under hw/rtl; depends on nothing.
package pcmx_pkg;

	localparam int CHANNELS_DEF   = 16;
	localparam int ADDR_BITS_DEF  = 20;

	localparam int CLOCK_HZ       = 4000000;
	localparam int CLOCK_DIV      = 166;
	// floor(floor(d*HZ/DIV)/rate) == floor(d*(HZ/2) / ((DIV/2)*rate))
	localparam int STEP_NUM       = CLOCK_HZ / 2;
	localparam int STEP_DEN       = CLOCK_DIV / 2;
	localparam int NUM_W          = 37;
	localparam int DEN_W          = 25;

	localparam int RATE_W         = 18;
	localparam int VSHIFT_W       = 4;
	localparam int ROMSZ_W        = 24;
	localparam int CFG_W          = 24;

	localparam logic [RATE_W-1:0]  RATE_RST  = 18'd44100;
	localparam logic [ROMSZ_W-1:0] ROMSZ_RST = 24'd1048576;

	localparam logic [1:0] CFG_RATE   = 2'd0;
	localparam logic [1:0] CFG_VSHIFT = 2'd1;
	localparam logic [1:0] CFG_ROMSZ  = 2'd2;

	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_TICK  = 2'd1;
	localparam logic [1:0] FUNC_LOAD  = 2'd2;

	localparam logic [2:0] REG_BANK  = 3'd0;
	localparam logic [2:0] REG_START = 3'd1;
	localparam logic [2:0] REG_PITCH = 3'd2;
	localparam logic [2:0] REG_LOOP  = 3'd4;
	localparam logic [2:0] REG_END   = 3'd5;
	localparam logic [2:0] REG_VOL   = 3'd6;

	typedef enum logic [2:0] {
		OP_BANK, OP_START, OP_PITCH, OP_STEP, OP_LOOP, OP_END, OP_VOL, OP_PAN
	} op_t;

	typedef struct packed {
		logic        en;
		op_t         op;
		logic [3:0]  ch;
		logic [31:0] data;
	} wr_t;

	typedef struct packed {
		logic [1:0]  key;
		logic [6:0]  bank;
		logic [15:0] start;
		logic [15:0] stop;
		logic [15:0] loop;
		logic [31:0] pos;
		logic [31:0] step;
		logic [15:0] vol;
		logic [5:0]  pan;
		logic        pan_set;
		logic [7:0]  nxt;
		logic [15:0] pstart;
	} chan_t;

	function automatic logic [8:0] pan_gain(input logic [5:0] idx);
		logic [8:0] g;
		case (idx)
			6'd0: g = 9'd0;     6'd1: g = 9'd45;    6'd2: g = 9'd64;    6'd3: g = 9'd78;
			6'd4: g = 9'd90;    6'd5: g = 9'd101;   6'd6: g = 9'd110;   6'd7: g = 9'd119;
			6'd8: g = 9'd128;   6'd9: g = 9'd135;   6'd10: g = 9'd143;  6'd11: g = 9'd150;
			6'd12: g = 9'd156;  6'd13: g = 9'd163;  6'd14: g = 9'd169;  6'd15: g = 9'd175;
			6'd16: g = 9'd181;  6'd17: g = 9'd186;  6'd18: g = 9'd191;  6'd19: g = 9'd197;
			6'd20: g = 9'd202;  6'd21: g = 9'd207;  6'd22: g = 9'd212;  6'd23: g = 9'd217;
			6'd24: g = 9'd221;  6'd25: g = 9'd226;  6'd26: g = 9'd230;  6'd27: g = 9'd235;
			6'd28: g = 9'd239;  6'd29: g = 9'd243;  6'd30: g = 9'd247;  6'd31: g = 9'd251;
			6'd32: g = 9'd256;
			default: g = 9'd0;
		endcase
		return g;
	endfunction

endpackage

>>> hw/rtl/pcmx_cell.sv
// One channel cell of the rotating state ring.
// Depends on pcmx_pkg (chan_t, wr_t, op_t).
module pcmx_cell #(
	parameter logic [3:0] IDX = 4'd0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift_en,
	input  pcmx_pkg::chan_t shift_in,
	input  pcmx_pkg::wr_t   wr,
	output pcmx_pkg::chan_t state
);

	pcmx_pkg::chan_t st_q;

	assign state = st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (shift_en) begin
			st_q <= shift_in;
		end else if (wr.en && wr.ch == IDX) begin
			case (wr.op)
				pcmx_pkg::OP_BANK:  st_q.bank  <= wr.data[6:0];
				pcmx_pkg::OP_START: st_q.start <= wr.data[15:0];
				pcmx_pkg::OP_PITCH: begin
					if (wr.data[15:0] == 16'd0) st_q.key <= 2'd0;
				end
				pcmx_pkg::OP_STEP:  st_q.step  <= wr.data;
				pcmx_pkg::OP_LOOP:  st_q.loop  <= wr.data[15:0];
				pcmx_pkg::OP_END:   st_q.stop  <= wr.data[15:0];
				pcmx_pkg::OP_VOL: begin
					st_q.vol <= wr.data[15:0];
					if (wr.data[15:0] == 16'd0) begin
						st_q.key <= 2'd0;
					end else if (st_q.key == 2'd0) begin
						// key on: latch start, jump there on the next tick
						st_q.pstart <= st_q.start;
						st_q.pos    <= 32'd0;
						st_q.key    <= 2'd3;
					end
				end
				pcmx_pkg::OP_PAN: begin
					st_q.pan     <= wr.data[5:0];
					st_q.pan_set <= 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

>>> hw/rtl/pcmx_divider.sv
// Restoring divider, one quotient bit per cycle, for the pitch step size.
// Depends on pcmx_pkg (NUM_W, DEN_W).
module pcmx_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pcmx_pkg::NUM_W-1:0]   num,
	input  logic [pcmx_pkg::DEN_W-1:0]   den,
	output logic                         done,
	output logic [31:0]                  quo
);

	localparam int NW = pcmx_pkg::NUM_W;
	localparam int DW = pcmx_pkg::DEN_W;
	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [NW-1:0] q_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          fit;

	assign trial = {rem_q, q_q[NW-1]};
	assign fit   = trial >= {1'b0, den_q};
	assign done  = done_q;
	assign quo   = q_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q   <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fit ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			q_q   <= {q_q[NW-2:0], fit};
		end
	end

endmodule

>>> hw/rtl/pcmx_voice.sv
// Voice engine at the head of the cell ring: reads sample bytes, interpolates,
// scales and accumulates one channel at a time. Holds the sample memory.
// Depends on pcmx_pkg (chan_t, pan_gain).
module pcmx_voice #(
	parameter int CHANNELS  = pcmx_pkg::CHANNELS_DEF,
	parameter int ADDR_BITS = pcmx_pkg::ADDR_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [pcmx_pkg::VSHIFT_W-1:0]     vshift,
	input  logic [pcmx_pkg::ROMSZ_W-1:0]      rom_size,
	input  pcmx_pkg::chan_t                   head,
	output logic                              shift_en,
	output pcmx_pkg::chan_t                   shift_out,
	input  logic                              mem_we,
	input  logic [ADDR_BITS-1:0]              mem_waddr,
	input  logic [7:0]                        mem_wdata,
	output logic                              done,
	output logic signed [39:0]                acc_l,
	output logic signed [39:0]                acc_r
);

	localparam int CNT_W = $clog2(CHANNELS + 1);

	typedef enum logic [2:0] {
		E_IDLE, E_CALC, E_RDN, E_RDC, E_MUL, E_SUM, E_VOL, E_ACC
	} est_t;

	est_t                   st_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   done_q;

	logic [7:0]             mem [(1 << ADDR_BITS)];
	logic [ADDR_BITS-1:0]   raddr;
	logic [7:0]             rd_q;

	logic [31:0]            pos_q;
	logic                   rdn_q;
	logic [ADDR_BITS-1:0]   naddr_q;
	logic [ADDR_BITS-1:0]   caddr_q;
	logic [1:0]             keyn_q;
	logic [15:0]            vl_q, vr_q;
	logic [7:0]             ns_q;
	logic signed [7:0]      cur_q;
	logic signed [21:0]     prod_q;
	logic signed [17:0]     s_q;
	logic signed [34:0]     ml_q, mr_q;
	logic signed [39:0]     accl_q, accr_q;

	// head channel decode
	logic [31:0]            pos_c, endv, el, pos_w, pos_sel, off_n;
	logic signed [32:0]     pos33, end33, lo33;
	logic                   ge, lt, rd_n, key_off;
	logic [22:0]            base;
	logic [23:0]            bank_top;
	logic [4:0]             vsh;
	logic [24:0]            gl_p, gr_p;
	logic [8:0]             gl, gr;
	logic signed [8:0]      diff;
	logic signed [21:0]     prod_adj;

	function automatic logic [ADDR_BITS-1:0] mem_addr(input logic [22:0] b,
			input logic [31:0] off);
		logic [31:0] a;
		a = {9'd0, b} + off;
		return a[ADDR_BITS-1:0];
	endfunction

	always_comb begin
		pos_c    = head.key[1] ? {4'd0, head.pstart, 12'd0} : head.pos;
		endv     = {4'd0, head.stop, 12'd0};
		el       = endv - {4'd0, head.loop, 12'd0};
		pos_w    = el + {20'd0, pos_c[11:0]};
		pos33    = $signed({pos_c[31], pos_c});
		end33    = $signed({1'b0, endv});
		lo33     = end33 - 33'sd4096;
		ge       = pos33 >= lo33;
		lt       = pos33 < end33;
		bank_top = {1'b0, head.bank, 16'd0} + 24'h010000;
		base     = (bank_top > rom_size) ? 23'd0 : {head.bank, 16'd0};
		pos_sel  = pos_c;
		rd_n     = 1'b1;
		key_off  = 1'b0;
		off_n    = {16'd0, pos_c[27:12]} + 32'd1;
		if (ge) begin
			if (head.loop != 16'd0) begin
				if (lt) begin
					off_n = {{12{el[31]}}, el[31:12]};
				end else begin
					pos_sel = pos_w;
					rd_n    = 1'b0;
				end
			end else if (lt) begin
				off_n = {16'd0, pos_c[27:12]};
			end else begin
				key_off = 1'b1;
			end
		end
		vsh  = 5'd10 + {1'b0, vshift};
		gl   = head.pan_set ? pcmx_pkg::pan_gain(6'd32 - head.pan) : 9'd0;
		gr   = head.pan_set ? pcmx_pkg::pan_gain(head.pan) : 9'd0;
		gl_p = (head.vol * gl) >> vsh;
		gr_p = (head.vol * gr) >> vsh;
		diff = $signed({ns_q[7], ns_q}) - $signed({rd_q[7], rd_q});
		prod_adj = prod_q + (prod_q < 0 ? 22'sd63 : 22'sd0);
	end

	always_comb begin
		case (st_q)
			E_RDN:   raddr = naddr_q;
			default: raddr = caddr_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_q <= mem[raddr];
	end

	// shift the head cell out once its channel is finished
	always_comb begin
		shift_en  = 1'b0;
		shift_out = head;
		if (st_q == E_CALC) begin
			if (head.key == 2'd0) begin
				shift_en = 1'b1;
			end else if (key_off) begin
				shift_en      = 1'b1;
				shift_out.key = 2'd0;
				shift_out.pos = pos_c;
			end
		end else if (st_q == E_ACC) begin
			shift_en      = 1'b1;
			shift_out.key = keyn_q;
			shift_out.nxt = ns_q;
			shift_out.pos = pos_q + head.step;
		end
	end

	assign done  = done_q;
	assign acc_l = accl_q;
	assign acc_r = accr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= E_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
			accl_q <= '0;
			accr_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				E_IDLE: begin
					if (start) begin
						st_q   <= E_CALC;
						cnt_q  <= '0;
						accl_q <= '0;
						accr_q <= '0;
					end
				end
				E_CALC: begin
					if (head.key == 2'd0 || key_off) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == CNT_W'(CHANNELS - 1)) begin
							st_q   <= E_IDLE;
							done_q <= 1'b1;
						end
					end else begin
						st_q <= E_RDN;
					end
				end
				E_RDN: st_q <= E_RDC;
				E_RDC: st_q <= E_MUL;
				E_MUL: st_q <= E_SUM;
				E_SUM: st_q <= E_VOL;
				E_VOL: st_q <= E_ACC;
				E_ACC: begin
					accl_q <= accl_q + 40'(ml_q);
					accr_q <= accr_q + 40'(mr_q);
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(CHANNELS - 1)) begin
						st_q   <= E_IDLE;
						done_q <= 1'b1;
					end else begin
						st_q <= E_CALC;
					end
				end
				default: st_q <= E_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			E_CALC: begin
				pos_q   <= pos_sel;
				rdn_q   <= rd_n;
				naddr_q <= mem_addr(base, off_n);
				caddr_q <= mem_addr(base, {16'd0, pos_sel[27:12]});
				keyn_q  <= head.key[1] ? {1'b0, head.key[0]} : head.key;
				vl_q    <= gl_p[15:0];
				vr_q    <= gr_p[15:0];
			end
			E_RDC: ns_q <= rdn_q ? rd_q : head.nxt;
			E_MUL: begin
				cur_q  <= $signed(rd_q);
				prod_q <= $signed({10'd0, pos_q[11:0]}) * 22'(diff);
			end
			E_SUM: s_q <= 18'(cur_q) * 18'sd64 + 18'(prod_adj >>> 6);
			E_VOL: begin
				ml_q <= 35'(s_q) * $signed({19'd0, vl_q});
				mr_q <= 35'(s_q) * $signed({19'd0, vr_q});
			end
			default: ;
		endcase
	end

endmodule

>>> hw/rtl/pcm_sample_mixer_16ch_unit.sv
// Top level of the sixteen-channel PCM sample mixer.
// Depends on pcmx_pkg, pcmx_cell, pcmx_divider and pcmx_voice.
//
// Usage:
//   s_* is the item stream: tuser carries the function (write, tick, load),
//   tdata the register address, register data, memory address and byte.
//   m_* carries one stereo result per tick. cfg_* writes output rate, extra
//   volume shift and sample memory size; the user must write it only while
//   the block is idle, which the block itself does not enforce.
// Sequencing:
//   A pitch write with a nonzero output rate runs the step divider; no new
//   item is taken until it is done. A tick walks the channel ring: a silent
//   or ending channel leaves from the decode state, a playing channel goes on
//   through two memory reads, interpolation, scaling and accumulate; then the
//   mix is published (done flag, then the load of the output register).
//   Channels share the single sample memory read port and the voice engine.
// Reset:
//   All channel state clears, the configuration returns to its defaults;
//   sample memory content is undefined until loaded.
// Stall:
//   A finished result is held in the output register; the next item is
//   still taken, and a later tick waits to publish until that slot frees.
module pcm_sample_mixer_16ch_unit #(
	parameter int CHANNELS         = pcmx_pkg::CHANNELS_DEF,
	parameter int SAMPLE_ADDR_BITS = pcmx_pkg::ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // reg_addr[7:0], reg_data[23:8], rom_addr[46:24], rom_byte[54:47]
	input  logic [1:0]  s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // left_sample[15:0], right_sample[31:16]
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [pcmx_pkg::CFG_W-1:0] cfg_data
);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_TICK, ST_PUSH} st_t;

	st_t st_q;

	// configuration registers
	logic [pcmx_pkg::RATE_W-1:0]   rate_q;
	logic [pcmx_pkg::VSHIFT_W-1:0] vshift_q;
	logic [pcmx_pkg::ROMSZ_W-1:0]  romsz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q   <= pcmx_pkg::RATE_RST;
			vshift_q <= '0;
			romsz_q  <= pcmx_pkg::ROMSZ_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pcmx_pkg::CFG_RATE:   rate_q   <= cfg_data[pcmx_pkg::RATE_W-1:0];
				pcmx_pkg::CFG_VSHIFT: vshift_q <= cfg_data[pcmx_pkg::VSHIFT_W-1:0];
				pcmx_pkg::CFG_ROMSZ:  romsz_q  <= cfg_data[pcmx_pkg::ROMSZ_W-1:0];
				default: ;
			endcase
		end
	end

	// unpack the input transfer
	logic [7:0]  reg_addr;
	logic [15:0] reg_data;
	logic [22:0] rom_addr;
	logic [7:0]  rom_byte;
	logic [1:0]  func;
	logic        acc;

	assign reg_addr = s_tdata[7:0];
	assign reg_data = s_tdata[23:8];
	assign rom_addr = s_tdata[46:24];
	assign rom_byte = s_tdata[54:47];
	assign func     = s_tuser;
	assign s_tready = (st_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;

	// decode a register write into a cell write
	pcmx_pkg::wr_t reg_wr, step_wr, cell_wr;
	logic [5:0]    pan_raw;
	logic          div_go;

	always_comb begin
		reg_wr      = '0;
		reg_wr.op   = pcmx_pkg::OP_START;
		reg_wr.data = {16'd0, reg_data};
		pan_raw     = 6'(reg_data + 16'h0030);
		div_go      = 1'b0;
		if (acc && func == pcmx_pkg::FUNC_WRITE) begin
			if (reg_addr >= 8'h80 && reg_addr < 8'h90) begin
				reg_wr.en   = 1'b1;
				reg_wr.op   = pcmx_pkg::OP_PAN;
				reg_wr.ch   = reg_addr[3:0];
				reg_wr.data = {26'd0, (pan_raw > 6'h20) ? 6'h20 : pan_raw};
			end else if (reg_addr < 8'h80) begin
				reg_wr.ch = reg_addr[6:3];
				case (reg_addr[2:0])
					pcmx_pkg::REG_BANK: begin
						reg_wr.en = 1'b1;
						reg_wr.op = pcmx_pkg::OP_BANK;
						reg_wr.ch = reg_addr[6:3] + 4'd1;
					end
					pcmx_pkg::REG_START: begin
						reg_wr.en = 1'b1;
						reg_wr.op = pcmx_pkg::OP_START;
					end
					pcmx_pkg::REG_PITCH: begin
						reg_wr.en = 1'b1;
						reg_wr.op = pcmx_pkg::OP_PITCH;
						div_go    = (rate_q != '0);
					end
					pcmx_pkg::REG_LOOP: begin
						reg_wr.en = 1'b1;
						reg_wr.op = pcmx_pkg::OP_LOOP;
					end
					pcmx_pkg::REG_END: begin
						reg_wr.en = 1'b1;
						reg_wr.op = pcmx_pkg::OP_END;
					end
					pcmx_pkg::REG_VOL: begin
						reg_wr.en = 1'b1;
						reg_wr.op = pcmx_pkg::OP_VOL;
					end
					default: ;
				endcase
			end
		end
	end

	// step size divider
	logic [3:0]  step_ch_q;
	logic        div_done;
	logic [31:0] div_quo;
	logic [pcmx_pkg::NUM_W-1:0] div_num;
	logic [pcmx_pkg::DEN_W-1:0] div_den;

	assign div_num = pcmx_pkg::NUM_W'(reg_data) * pcmx_pkg::NUM_W'(pcmx_pkg::STEP_NUM);
	assign div_den = pcmx_pkg::DEN_W'(rate_q) * pcmx_pkg::DEN_W'(pcmx_pkg::STEP_DEN);

	pcmx_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_go),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_comb begin
		step_wr      = '0;
		step_wr.en   = div_done;
		step_wr.op   = pcmx_pkg::OP_STEP;
		step_wr.ch   = step_ch_q;
		step_wr.data = div_quo;
		cell_wr      = div_done ? step_wr : reg_wr;
	end

	// channel cell ring; the voice engine refills the tail
	pcmx_pkg::chan_t cell_st [CHANNELS];
	pcmx_pkg::chan_t eng_out;
	logic            eng_shift;

	for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
		pcmx_pkg::chan_t sin;
		if (i == CHANNELS - 1) begin : g_tail
			assign sin = eng_out;
		end else begin : g_body
			assign sin = cell_st[i+1];
		end
		pcmx_cell #(.IDX(4'(i))) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift_en(eng_shift),
			.shift_in(sin),
			.wr      (cell_wr),
			.state   (cell_st[i])
		);
	end

	logic                     eng_done;
	logic signed [39:0]       eng_l, eng_r;
	logic                     eng_start;

	assign eng_start = acc && func == pcmx_pkg::FUNC_TICK;

	pcmx_voice #(
		.CHANNELS (CHANNELS),
		.ADDR_BITS(SAMPLE_ADDR_BITS)
	) u_voice (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (eng_start),
		.vshift   (vshift_q),
		.rom_size (romsz_q),
		.head     (cell_st[0]),
		.shift_en (eng_shift),
		.shift_out(eng_out),
		.mem_we   (acc && func == pcmx_pkg::FUNC_LOAD),
		.mem_waddr(rom_addr[SAMPLE_ADDR_BITS-1:0]),
		.mem_wdata(rom_byte),
		.done     (eng_done),
		.acc_l    (eng_l),
		.acc_r    (eng_r)
	);

	// floor shift by 8, then clip to 16 bits
	function automatic logic [15:0] clip16(input logic signed [39:0] a);
		logic signed [31:0] v;
		v = 32'(a >>> 8);
		if (v > 32'sd32767) return 16'h7FFF;
		if (v < -32'sd32768) return 16'h8000;
		return v[15:0];
	endfunction

	logic        out_v_q;
	logic [31:0] out_d_q;
	logic        push;

	assign push     = (st_q == ST_PUSH) && (!out_v_q || m_tready);
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			out_v_q   <= 1'b0;
			step_ch_q <= '0;
		end else begin
			if (push) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (div_go) begin
						st_q      <= ST_DIV;
						step_ch_q <= reg_addr[6:3];
					end else if (eng_start) begin
						st_q <= ST_TICK;
					end
				end
				ST_DIV:  if (div_done) st_q <= ST_IDLE;
				ST_TICK: if (eng_done) st_q <= ST_PUSH;
				ST_PUSH: if (push) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) out_d_q <= {clip16(eng_r), clip16(eng_l)};
	end

endmodule

>>> dv/tb_pcm_sample_mixer_16ch_unit.sv
// Self-checking testbench for pcm_sample_mixer_16ch_unit: a mixer scoreboard class
// predicts each stereo result; plain tasks drive the item stream and the config port.
// Depends on pcmx_pkg and the mixer RTL under hw/rtl.
`timescale 1ns / 100ps

module tb_pcm_sample_mixer_16ch_unit;

	localparam logic [1:0] FUNC_NONE  = 2'd3;   // reserved function, block ignores it
	localparam logic [2:0] REG_GAP3   = 3'd3;   // unused register slots
	localparam logic [2:0] REG_GAP7   = 3'd7;
	localparam logic [7:0] PAN_BASE   = 8'h80;
	localparam logic [7:0] ADDR_LIMIT = 8'h90;
	localparam int MEM_AW        = 20;
	// end points stay at or below this byte offset, so every read hits loaded bytes
	localparam int END_MAX       = 'h7F;
	localparam int WATCHDOG_MAX  = 4000;
	localparam int SETTLE_CYCLES = 200;
	localparam int RANDOM_ITEMS  = 90;

	// Predicts the clipped stereo mix of every tick and holds the mixes still owed.
	class mix_scoreboard;
		bit [1:0]  key[16];
		bit [6:0]  bank[16];
		bit [31:0] start_q[16], end_q[16], loop_q[16], pos_q[16], step_q[16], pstart[16];
		bit [15:0] vol[16];
		bit [5:0]  pan[16];
		bit        pan_on[16];
		bit [7:0]  nxt[16];
		bit [7:0]  mem[1 << MEM_AW];
		bit [17:0] rate;
		bit [3:0]  vshift;
		bit [23:0] romsz;
		int unsigned gain_tab[33] = '{0, 45, 64, 78, 90, 101, 110, 119, 128, 135, 143, 150,
			156, 163, 169, 175, 181, 186, 191, 197, 202, 207, 212, 217, 221, 226, 230, 235,
			239, 243, 247, 251, 256};
		bit [31:0] expected_mix[$];
		int errors;

		function new();
			rate = pcmx_pkg::RATE_RST;
			vshift = 0;
			romsz = pcmx_pkg::ROMSZ_RST;
			errors = 0;
		endfunction

		function void set_config(logic [1:0] idx, logic [23:0] val);
			case (idx)
				pcmx_pkg::CFG_RATE:   rate = val[17:0];
				pcmx_pkg::CFG_VSHIFT: vshift = val[3:0];
				pcmx_pkg::CFG_ROMSZ:  romsz = val;
				default: ;
			endcase
		endfunction

		// bank of sample memory a bank select actually reads under the current size
		function int eff_bank(bit [6:0] b);
			if ((longint'(b) + 1) * 65536 > longint'(romsz)) return 0;
			return b & 15;
		endfunction

		function bit [7:0] rd(bit [31:0] base, bit [31:0] off);
			bit [31:0] a;
			a = base + off;
			return mem[a[MEM_AW-1:0]];
		endfunction

		function void reg_write(bit [7:0] a, bit [15:0] d);
			bit [5:0] p;
			int ch;
			if (a >= ADDR_LIMIT) return;
			if (a >= PAN_BASE) begin
				p = 6'(d + 16'h30);
				if (p > 6'h20) p = 6'h20;
				ch = a[3:0];
				pan[ch] = p;
				pan_on[ch] = 1;
				return;
			end
			ch = a[6:3];
			case (a[2:0])
				pcmx_pkg::REG_BANK:  bank[(ch + 1) % 16] = d[6:0];
				pcmx_pkg::REG_START: start_q[ch] = {d, 12'h0};
				pcmx_pkg::REG_PITCH: begin
					if (rate != 0)
						step_q[ch] = 32'(longint'(d) * pcmx_pkg::CLOCK_HZ / pcmx_pkg::CLOCK_DIV
							/ longint'(rate));
					if (d == 0) key[ch] = 0;
				end
				pcmx_pkg::REG_LOOP:  loop_q[ch] = {d, 12'h0};
				pcmx_pkg::REG_END:   end_q[ch] = {d, 12'h0};
				pcmx_pkg::REG_VOL: begin
					vol[ch] = d;
					if (d == 0) key[ch] = 0;
					else if (key[ch] == 0) begin
						pstart[ch] = start_q[ch];
						pos_q[ch] = 0;
						key[ch] = 3;
					end
				end
				default: ;
			endcase
		endfunction

		function void voice(int c, ref longint accl, ref longint accr);
			longint vl, vr, endv;
			bit [31:0] base, pos, p, diff;
			int cur, nb, s;
			vl = longint'((32'(vol[c]) * (pan_on[c] ? gain_tab[32 - pan[c]] : 0)) >> (10 + vshift));
			vr = longint'((32'(vol[c]) * (pan_on[c] ? gain_tab[pan[c]] : 0)) >> (10 + vshift));
			base = 32'(eff_bank(bank[c])) << 16;
			endv = longint'(end_q[c]);
			if (key[c][1]) begin
				key[c][1] = 0;
				pos_q[c] = pstart[c];
			end
			pos = pos_q[c];
			p = (pos >> 12) & 32'hFFFF;
			if (longint'(int'(pos)) >= endv - 4096) begin
				if (loop_q[c] != 0) begin
					if (longint'(int'(pos)) < endv) begin
						diff = end_q[c] - loop_q[c];
						nxt[c] = rd(base, 32'(int'(diff) >>> 12));
					end else begin
						pos = end_q[c] - loop_q[c] + (pos & 32'hFFF);
						p = (pos >> 12) & 32'hFFFF;
					end
				end else if (longint'(int'(pos)) < endv) begin
					nxt[c] = rd(base, p);
				end else begin
					key[c] = 0;
					pos_q[c] = pos;
					return;
				end
			end else begin
				nxt[c] = rd(base, p + 1);
			end
			cur = int'(signed'(rd(base, p)));
			nb = int'(signed'(nxt[c]));
			s = cur * 64 + (int'(pos & 32'hFFF) * (nb - cur)) / 64;
			accl += longint'(s) * vl;
			accr += longint'(s) * vr;
			pos_q[c] = pos + step_q[c];
		endfunction

		function bit [15:0] clip(longint acc);
			longint v;
			v = acc >>> 8;
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			return v[15:0];
		endfunction

		// fold one accepted transfer into the model; a tick owes one mix
		function void note_item(bit [1:0] f, bit [7:0] a, bit [15:0] d, bit [22:0] ra,
			bit [7:0] rb);
			longint accl, accr;
			if (f == pcmx_pkg::FUNC_WRITE) reg_write(a, d);
			else if (f == pcmx_pkg::FUNC_LOAD) mem[ra[MEM_AW-1:0]] = rb;
			else if (f == pcmx_pkg::FUNC_TICK) begin
				accl = 0;
				accr = 0;
				for (int c = 0; c < 16; c++)
					if (key[c] != 0) voice(c, accl, accr);
				expected_mix.push_back({clip(accr), clip(accl)});
			end
		endfunction

		task report(string what, int got, int want);
			$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
			errors++;
		endtask

		task check_mix(bit [31:0] got);
			bit [31:0] want;
			if (expected_mix.size() == 0) begin
				report("unexpected mix", got, 0);
				return;
			end
			want = expected_mix.pop_front();
			if (got[15:0] != want[15:0])
				report("left_sample", int'(signed'(got[15:0])), int'(signed'(want[15:0])));
			if (got[31:16] != want[31:16])
				report("right_sample", int'(signed'(got[31:16])), int'(signed'(want[31:16])));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;   // reg_addr[7:0], reg_data[23:8], rom_addr[46:24], rom_byte[54:47]
	logic [1:0]  s_tuser;   // func
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // left_sample[15:0], right_sample[31:16]
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [pcmx_pkg::CFG_W-1:0] cfg_data;

	mix_scoreboard sb;
	int src_idle_pct;
	int sink_stall_pct;
	int quiet_cycles;

	pcm_sample_mixer_16ch_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Receiver: stall at the configured rate, decided fresh at each falling edge.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Check every result transfer; the watchdog trips when nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_mix(m_tdata);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_MAX) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Present one item at a falling edge, hold it until the transfer, then note it.
	// Entered and left at a falling edge; the valid drop at the end is settled at
	// once so a following item may raise it again in the same falling edge.
	task send_item(logic [1:0] f, logic [7:0] a, logic [15:0] d, logic [22:0] ra,
		logic [7:0] rb);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = f;
		s_tdata  = {1'b0, rb, ra, d, a};
		do @(posedge clk); while (!s_tready);
		sb.note_item(f, a, d, ra, rb);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task put_reg(int ch, logic [2:0] r, logic [15:0] d);
		send_item(pcmx_pkg::FUNC_WRITE, {1'b0, 4'(ch), r}, d, 23'($urandom), 8'($urandom));
	endtask

	task put_pan(int ch, logic [15:0] d);
		send_item(pcmx_pkg::FUNC_WRITE, PAN_BASE | 8'(ch), d, 23'($urandom), 8'($urandom));
	endtask

	task tick();
		send_item(pcmx_pkg::FUNC_TICK, 8'($urandom), 16'($urandom), 23'($urandom),
			8'($urandom));
	endtask

	// pick a bank select that reads only loaded memory under the current size
	function logic [15:0] safe_bank();
		logic [15:0] d;
		do d = 16'($urandom); while (sb.eff_bank(d[6:0]) > 1);
		return d;
	endfunction

	// Wait for every owed mix, then let trailing no-result work finish.
	task settle();
		while (sb.expected_mix.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task write_cfg(logic [1:0] idx, logic [pcmx_pkg::CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_config(idx, val);
		@(negedge clk);
	endtask

	task random_item();
		int roll, ch, lo;
		logic [15:0] d;
		roll = $urandom_range(99);
		ch = $urandom_range(15);
		if (roll < 35) begin
			tick();
		end else if (roll < 82) begin
			case ($urandom_range(6))
				0: put_reg(ch, pcmx_pkg::REG_BANK, safe_bank());
				1: put_reg(ch, pcmx_pkg::REG_START, ($urandom_range(3) == 0) ? 16'($urandom)
					: 16'($urandom_range(0, 64)));
				2: begin
					// mostly audible steps, sometimes the full word, rarely a key-off
					case ($urandom_range(9))
						0: d = 16'h0;
						1, 2: d = 16'($urandom);
						default: d = 16'($urandom_range(1, 64));
					endcase
					put_reg(ch, pcmx_pkg::REG_PITCH, d);
				end
				3: put_reg(ch, pcmx_pkg::REG_LOOP, 16'($urandom_range(0, sb.end_q[ch] >> 12)));
				4: begin
					// keep the end at or past the loop length and inside loaded memory
					lo = sb.loop_q[ch] >> 12;
					d = 16'($urandom_range(lo, END_MAX));
					put_reg(ch, pcmx_pkg::REG_END, d);
				end
				5: put_reg(ch, pcmx_pkg::REG_VOL, ($urandom_range(9) == 0) ? 16'h0
					: 16'($urandom));
				default: put_pan(ch, 16'($urandom));
			endcase
		end else if (roll < 90) begin
			send_item(pcmx_pkg::FUNC_LOAD, 8'($urandom), 16'($urandom), 23'($urandom),
				8'($urandom));
		end else begin
			// noise the block must ignore
			case ($urandom_range(3))
				0: send_item(FUNC_NONE, 8'($urandom), 16'($urandom), 23'($urandom),
					8'($urandom));
				1: send_item(pcmx_pkg::FUNC_WRITE, 8'($urandom_range(ADDR_LIMIT, 255)),
					16'($urandom), 23'($urandom), 8'($urandom));
				2: put_reg(ch, REG_GAP3, 16'($urandom));
				default: put_reg(ch, REG_GAP7, 16'($urandom));
			endcase
		end
	endtask

	task run_phase(logic [17:0] rate, logic [3:0] vsh, logic [23:0] romsz, int src, int sink);
		settle();
		write_cfg(pcmx_pkg::CFG_RATE, pcmx_pkg::CFG_W'(rate));
		write_cfg(pcmx_pkg::CFG_VSHIFT, pcmx_pkg::CFG_W'(vsh));
		write_cfg(pcmx_pkg::CFG_ROMSZ, romsz);
		src_idle_pct = src;
		sink_stall_pct = sink;
		// re-point every bank so the new size never exposes unloaded memory
		for (int c = 0; c < 16; c++) put_reg(c, pcmx_pkg::REG_BANK, safe_bank());
		for (int i = 0; i < RANDOM_ITEMS; i++) random_item();
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = pcmx_pkg::FUNC_WRITE;
		m_tready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = pcmx_pkg::CFG_RATE;
		cfg_data = '0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		quiet_cycles = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Load the low bytes of banks 0 and 1 up to the highest end point before any
		// tick reads memory.
		for (int b = 0; b < 2; b++)
			for (int a = 0; a <= END_MAX; a++)
				send_item(pcmx_pkg::FUNC_LOAD, 8'($urandom), 16'($urandom),
					{3'($urandom), 20'(b * 'h10000 + a)},
					(b == 0 && a == 0) ? 8'h80 : (b == 0 && a == 1) ? 8'h7F : 8'($urandom));

		// Directed: silent tick, looping voices, a voice that runs off its end, ignored writes, key-offs.
		tick();
		put_reg(15, pcmx_pkg::REG_BANK, 16'h0010);  // wraps to channel 0, maps to bank 0
		put_reg(0, pcmx_pkg::REG_START, 16'h0000);
		put_reg(0, pcmx_pkg::REG_END, 16'h0010);
		put_reg(0, pcmx_pkg::REG_LOOP, 16'h0004);
		put_reg(0, pcmx_pkg::REG_PITCH, 16'h0008);
		put_pan(0, 16'h0010);                       // hard left
		put_reg(0, pcmx_pkg::REG_VOL, 16'hFFFF);
		tick();
		tick();
		put_pan(1, 16'h000F);                       // saturates hard right
		put_reg(1, pcmx_pkg::REG_END, 16'h0002);
		put_reg(1, pcmx_pkg::REG_PITCH, 16'hFFFF);
		put_reg(1, pcmx_pkg::REG_VOL, 16'h1234);
		put_pan(2, 16'hFFFF);
		put_reg(2, pcmx_pkg::REG_END, 16'(END_MAX));
		put_reg(2, pcmx_pkg::REG_LOOP, 16'(END_MAX));
		put_reg(2, pcmx_pkg::REG_PITCH, 16'h0001);
		put_reg(2, pcmx_pkg::REG_VOL, 16'hFFFF);
		tick();
		tick();
		put_reg(3, REG_GAP3, 16'hFFFF);
		put_reg(3, REG_GAP7, 16'hFFFF);
		send_item(pcmx_pkg::FUNC_WRITE, ADDR_LIMIT, 16'hFFFF, 23'h0, 8'h0);
		send_item(FUNC_NONE, 8'hFF, 16'hFFFF, 23'h7FFFFF, 8'hFF);
		put_reg(0, pcmx_pkg::REG_PITCH, 16'h0000);  // key off by pitch
		put_reg(2, pcmx_pkg::REG_VOL, 16'h0000);    // key off by volume
		tick();

		run_phase(18'd44100, 4'd0, 24'd1048576, 0, 0);
		run_phase(18'd192000, 4'd15, 24'd65536, 83, 0);
		run_phase(18'd1, 4'd3, 24'd8388608, 0, 83);
		run_phase(18'd0, 4'd1, 24'd131072, 14, 14);
		run_phase(18'd22050, 4'd0, 24'd1048576, 0, 0);

		settle();
		if (sb.errors == 0 && sb.expected_mix.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
